[hdl/ilv_pkg.sv]
`timescale 1ns / 1ps

package ilv_pkg;

  localparam int LANES = 4;
  localparam int QUEUE_DEPTH = 2;

  // Lane order: binary, octal, decimal, hex
  localparam logic [1:0] LANE_BIN = 2'd0;
  localparam logic [1:0] LANE_OCT = 2'd1;
  localparam logic [1:0] LANE_DEC = 2'd2;
  localparam logic [1:0] LANE_HEX = 2'd3;

  localparam logic [4:0] LANE_BASE  [LANES] = '{5'd2, 5'd8, 5'd10, 5'd16};
  localparam logic [6:0] LANE_LIMIT [LANES] = '{7'd64, 7'd22, 7'd20, 7'd16};
  localparam logic [7:0] LANE_PREFIX[LANES] = '{8'h62, 8'h6f, 8'h00, 8'h78};

  localparam logic [2:0] MODE_ANY = 3'd0;
  localparam logic [2:0] MODE_BIN = 3'd1;
  localparam logic [2:0] MODE_OCT = 3'd2;
  localparam logic [2:0] MODE_DEC = 3'd3;
  localparam logic [2:0] MODE_HEX = 3'd4;

  localparam logic [1:0] SIGN_NONE  = 2'd0;
  localparam logic [1:0] SIGN_PLUS  = 2'd1;
  localparam logic [1:0] SIGN_MINUS = 2'd2;

  // Character position, saturating once past the prefix
  localparam logic [1:0] POS_FIRST  = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_THIRD  = 2'd2;
  localparam logic [1:0] POS_LATER  = 2'd3;

  localparam logic [7:0] CHAR_ZERO       = 8'h30;
  localparam logic [7:0] CHAR_NINE       = 8'h39;
  localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
  localparam logic [7:0] CHAR_LOWER_F    = 8'h66;
  localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
  localparam logic [7:0] CHAR_UPPER_F    = 8'h46;
  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5f;
  localparam logic [7:0] CHAR_MINUS      = 8'h2d;
  localparam logic [7:0] CHAR_PLUS       = 8'h2b;

  localparam logic [4:0] NOT_A_DIGIT = 5'd16;

  typedef struct packed {
    logic [4:0]       digit;
    logic             is_zero;
    logic             is_underscore;
    logic             is_sign;
    logic [LANES-1:0] prefix_hit;
    logic [1:0]       pos;
    logic [1:0]       sign;
    logic [2:0]       mode;
    logic             last;
  } item_t;

  // value * base for a lane, kept wide so overflow shows in the top bits
  function automatic logic [67:0] lane_scale(input logic [1:0] lane, input logic [63:0] v);
    logic [67:0] w;
    w = {4'b0, v};
    case (lane)
      LANE_BIN: lane_scale = w << 1;
      LANE_OCT: lane_scale = w << 3;
      LANE_DEC: lane_scale = (w << 3) + (w << 1);
      LANE_HEX: lane_scale = w << 4;
      default:  lane_scale = '0;
    endcase
  endfunction

endpackage

[hdl/integer_literal_validator.sv]
`timescale 1ns / 1ps

// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall   char_code[7:0], last_char, base_mode[2:0]
// out      output     out_valid / out_stall is_valid
//
// One item a cycle sustained while in_stall is low; the item marked last is
// registered in the queue, then its verdict is driven from the output register.
// The front classifies a character in the cycle it is taken; the back runs
// all four lane accumulators on one queued item per cycle unless a verdict stalls.
// rst is synchronous and clears position, mode, lanes, queue and output.
// in_stall rises only while the queue is full; a stalled verdict holds the
// back only when the next queued item is also a last character.

module integer_literal_validator #(
  parameter int QUEUE_DEPTH = ilv_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] char_code,
  input  logic       last_char,
  input  logic [2:0] base_mode,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       is_valid,
  output logic       out_valid,
  input  logic       out_stall
);
  import ilv_pkg::*;

  logic  push;
  logic  q_pop;
  logic  q_valid;
  item_t push_item;
  item_t q_item;

  assign push = in_valid && !in_stall;

  ilv_front u_front (
    .clk       (clk),
    .rst       (rst),
    .char_code (char_code),
    .last_char (last_char),
    .base_mode (base_mode),
    .push      (push),
    .push_item (push_item)
  );

  ilv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (in_stall),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head_item (q_item)
  );

  ilv_back u_back (
    .clk       (clk),
    .rst       (rst),
    .not_empty (q_valid),
    .head_item (q_item),
    .pop       (q_pop),
    .is_valid  (is_valid),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

`ifndef SYNTHESIS
  a_pop_needs_item: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_no_verdict_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !(q_pop && q_item.last))
    else $error("verdict overwritten while stalled");

  a_full_not_empty: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> q_valid)
    else $error("queue full but reports empty");
`endif

endmodule

[hdl/ilv_front.sv]
`timescale 1ns / 1ps

module ilv_front (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        char_code,
  input  logic              last_char,
  input  logic [2:0]        base_mode,
  input  logic              push,
  output ilv_pkg::item_t    push_item
);
  import ilv_pkg::*;

  logic [1:0] pos;
  logic [2:0] mode_held;
  logic [1:0] sign_seen;
  logic [1:0] cur_sign;
  logic [4:0] digit;

  always_comb begin
    if (char_code >= CHAR_ZERO && char_code <= CHAR_NINE) begin
      digit = 5'(char_code - CHAR_ZERO);
    end else if (char_code >= CHAR_LOWER_A && char_code <= CHAR_LOWER_F) begin
      digit = 5'(char_code - CHAR_LOWER_A) + 5'd10;
    end else if (char_code >= CHAR_UPPER_A && char_code <= CHAR_UPPER_F) begin
      digit = 5'(char_code - CHAR_UPPER_A) + 5'd10;
    end else begin
      digit = NOT_A_DIGIT;
    end
  end

  always_comb begin
    if (char_code == CHAR_MINUS) begin
      cur_sign = SIGN_MINUS;
    end else if (char_code == CHAR_PLUS) begin
      cur_sign = SIGN_PLUS;
    end else begin
      cur_sign = SIGN_NONE;
    end
  end

  always_comb begin
    push_item.digit         = digit;
    push_item.is_zero       = (char_code == CHAR_ZERO);
    push_item.is_underscore = (char_code == CHAR_UNDERSCORE);
    push_item.is_sign       = (cur_sign != SIGN_NONE);
    for (int l = 0; l < LANES; l++) begin
      push_item.prefix_hit[l] = (char_code == LANE_PREFIX[l]);
    end
    push_item.pos  = pos;
    push_item.sign = (pos == POS_FIRST) ? cur_sign : sign_seen;
    push_item.mode = (pos == POS_FIRST) ? base_mode : mode_held;
    push_item.last = last_char;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= POS_FIRST;
      mode_held <= MODE_ANY;
      sign_seen <= SIGN_NONE;
    end else if (push) begin
      if (last_char) begin
        pos       <= POS_FIRST;
        mode_held <= MODE_ANY;
        sign_seen <= SIGN_NONE;
      end else begin
        if (pos != POS_LATER) begin
          pos <= pos + 2'd1;
        end
        if (pos == POS_FIRST) begin
          mode_held <= base_mode;
          sign_seen <= cur_sign;
        end
      end
    end
  end

endmodule

[hdl/ilv_queue.sv]
`timescale 1ns / 1ps

module ilv_queue #(
  parameter int DEPTH = ilv_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ilv_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output ilv_pkg::item_t head_item
);
  import ilv_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

[hdl/ilv_back.sv]
`timescale 1ns / 1ps

module ilv_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           not_empty,
  input  ilv_pkg::item_t head_item,
  output logic           pop,
  output logic           is_valid,
  output logic           out_valid,
  input  logic           out_stall
);
  import ilv_pkg::*;

  logic [63:0] lane_value      [LANES];
  logic [6:0]  lane_count      [LANES];
  logic        lane_ok         [LANES];
  logic [63:0] lane_value_next [LANES];
  logic [6:0]  lane_count_next [LANES];
  logic        lane_ok_next    [LANES];
  logic [67:0] lane_sum        [LANES];
  logic        body_first      [LANES];
  logic [LANES-1:0] lane_pass;
  logic        fits_dec;
  logic        verdict;

  // A last item needs a free output slot; others go straight through
  assign pop = not_empty && (!head_item.last || !out_valid || !out_stall);

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      lane_value_next[l] = lane_value[l];
      lane_count_next[l] = lane_count[l];
      lane_ok_next[l]    = lane_ok[l];
      lane_sum[l]        = lane_scale(2'(l), lane_value[l]) + 68'(head_item.digit);
      if (2'(l) == LANE_DEC) begin
        body_first[l] = (head_item.pos == POS_FIRST) ||
                        (head_item.pos == POS_SECOND && head_item.sign != SIGN_NONE);
      end else begin
        body_first[l] = (head_item.pos == POS_THIRD);
      end
      if (lane_ok[l]) begin
        if (2'(l) != LANE_DEC && head_item.pos == POS_FIRST) begin
          lane_ok_next[l] = head_item.is_zero;
        end else if (2'(l) != LANE_DEC && head_item.pos == POS_SECOND) begin
          lane_ok_next[l] = head_item.prefix_hit[l];
        end else if (2'(l) == LANE_DEC && head_item.pos == POS_FIRST &&
                     head_item.is_sign) begin
          lane_ok_next[l] = 1'b1;
        end else if (head_item.is_underscore) begin
          if (body_first[l]) begin
            lane_ok_next[l] = 1'b0;
          end
        end else if (head_item.digit >= LANE_BASE[l] ||
                     lane_count[l] >= LANE_LIMIT[l] ||
                     lane_sum[l][67:64] != 4'd0) begin
          lane_ok_next[l] = 1'b0;
        end else begin
          lane_value_next[l] = lane_sum[l][63:0];
          lane_count_next[l] = lane_count[l] + 7'd1;
        end
      end
    end
  end

  // Decimal magnitude: up to 2^63 after a minus, below 2^63 otherwise
  always_comb begin
    if (head_item.sign == SIGN_MINUS) begin
      fits_dec = !lane_value_next[LANE_DEC][63] || (lane_value_next[LANE_DEC][62:0] == '0);
    end else begin
      fits_dec = !lane_value_next[LANE_DEC][63];
    end
    for (int l = 0; l < LANES; l++) begin
      lane_pass[l] = lane_ok_next[l] && (lane_count_next[l] != 7'd0) &&
                     ((2'(l) != LANE_DEC) || fits_dec);
    end
    case (head_item.mode)
      MODE_ANY: verdict = |lane_pass;
      MODE_BIN: verdict = lane_pass[LANE_BIN];
      MODE_OCT: verdict = lane_pass[LANE_OCT];
      MODE_DEC: verdict = lane_pass[LANE_DEC];
      MODE_HEX: verdict = lane_pass[LANE_HEX];
      default:  verdict = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < LANES; l++) begin
        lane_value[l] <= '0;
        lane_count[l] <= '0;
        lane_ok[l]    <= 1'b1;
      end
    end else if (pop) begin
      for (int l = 0; l < LANES; l++) begin
        if (head_item.last) begin
          lane_value[l] <= '0;
          lane_count[l] <= '0;
          lane_ok[l]    <= 1'b1;
        end else begin
          lane_value[l] <= lane_value_next[l];
          lane_count[l] <= lane_count_next[l];
          lane_ok[l]    <= lane_ok_next[l];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && head_item.last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_item.last) begin
      is_valid <= verdict;
    end
  end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import ilv_pkg::*;

  localparam logic [2:0] MODE_BAD = 3'd7;
  localparam int TARGET_CHARS = 1700;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 120;
  localparam int BURST_LEN = 30;

  typedef struct {
    logic [7:0] code;
    logic       last;
    logic [2:0] mode;
    bit         pause;
  } char_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic [7:0] char_code = 8'd0;
  logic       last_char = 1'b0;
  logic [2:0] base_mode = MODE_ANY;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       is_valid;
  logic       out_valid;
  logic       out_stall = 1'b0;

  char_item_t char_feed[$];
  logic [7:0] lit[$];
  bit         verdicts_due[$];

  int  queued_chars = 0;
  int  chars_taken = 0;
  int  verdicts_checked = 0;
  int  valid_verdicts = 0;
  int  mismatches = 0;
  int  quiet_cycles = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  bit  burst_go = 1'b0;
  bit  burst_queued = 1'b0;
  bit  in_taken = 1'b0;

  // scanner state mirrored from the block
  logic [6:0]  scan_pos;
  logic [2:0]  held_mode;
  logic [1:0]  held_sign;
  logic [63:0] lane_val[LANES];
  logic [6:0]  lane_cnt[LANES];
  logic        lane_ok[LANES];

  integer_literal_validator u_dut (
    .clk       (clk),
    .rst       (rst),
    .char_code (char_code),
    .last_char (last_char),
    .base_mode (base_mode),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .is_valid  (is_valid),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

  always #1 clk = ~clk;

  function automatic bit calm();
    return chars_taken >= 1000 && chars_taken < 1300;
  endfunction

  task automatic clear_scan();
    int l;
    scan_pos = '0;
    held_mode = MODE_ANY;
    held_sign = SIGN_NONE;
    for (l = 0; l < LANES; l++) begin
      lane_val[l] = '0;
      lane_cnt[l] = '0;
      lane_ok[l] = 1'b1;
    end
  endtask

  function automatic logic [4:0] digit_value(logic [7:0] c);
    if (c >= CHAR_ZERO && c <= CHAR_NINE) return 5'(c - CHAR_ZERO);
    if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) return 5'(c - CHAR_LOWER_A) + 5'd10;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) return 5'(c - CHAR_UPPER_A) + 5'd10;
    return NOT_A_DIGIT;
  endfunction

  task automatic lane_feed(int l, logic [7:0] c, logic [6:0] p);
    bit          body_first;
    logic [4:0]  d;
    logic [63:0] b;
    b = 64'(LANE_BASE[l]);
    if (!lane_ok[l]) return;
    if (l != LANE_DEC) begin
      if (p == 7'd0) begin
        lane_ok[l] = (c == CHAR_ZERO);
        return;
      end
      if (p == 7'd1) begin
        lane_ok[l] = (c == LANE_PREFIX[l]);
        return;
      end
      body_first = (p == 7'd2);
    end else begin
      if (p == 7'd0 && (c == CHAR_MINUS || c == CHAR_PLUS)) return;
      body_first = (p == 7'd0) || (p == 7'd1 && held_sign != SIGN_NONE);
    end
    if (c == CHAR_UNDERSCORE) begin
      if (body_first) lane_ok[l] = 1'b0;
      return;
    end
    d = digit_value(c);
    if (d >= LANE_BASE[l] || lane_cnt[l] >= LANE_LIMIT[l] ||
        lane_val[l] > (~64'd0 - 64'(d)) / b) begin
      lane_ok[l] = 1'b0;
      return;
    end
    lane_val[l] = lane_val[l] * b + 64'(d);
    lane_cnt[l] = lane_cnt[l] + 7'd1;
  endtask

  function automatic bit lane_good(int l);
    if (!lane_ok[l] || lane_cnt[l] == 7'd0) return 1'b0;
    if (l != LANE_DEC) return 1'b1;
    return lane_val[l] <= ((held_sign == SIGN_MINUS) ? 64'h8000_0000_0000_0000
                                                     : 64'h7FFF_FFFF_FFFF_FFFF);
  endfunction

  task automatic scan_char(input logic [7:0] c, input logic last, input logic [2:0] m,
                           output bit has_verdict, output bit verdict);
    int l;
    if (scan_pos == 7'd0) begin
      held_mode = m;
      if (c == CHAR_MINUS) held_sign = SIGN_MINUS;
      else if (c == CHAR_PLUS) held_sign = SIGN_PLUS;
    end
    for (l = 0; l < LANES; l++) lane_feed(l, c, scan_pos);
    if (scan_pos != 7'd127) scan_pos = scan_pos + 7'd1;
    has_verdict = last;
    verdict = 1'b0;
    if (last) begin
      case (held_mode)
        MODE_ANY: verdict = lane_good(0) || lane_good(1) || lane_good(2) || lane_good(3);
        MODE_BIN, MODE_OCT, MODE_DEC, MODE_HEX: verdict = lane_good(int'(held_mode - MODE_BIN));
        default: verdict = 1'b0;
      endcase
      clear_scan();
    end
  endtask

  task automatic put_char(logic [7:0] c);
    lit.push_back(c);
  endtask

  task automatic put_text(string t);
    int i;
    for (i = 0; i < t.len(); i++) lit.push_back(t[i]);
  endtask

  task automatic send_literal(logic [2:0] m, bit pause);
    int i;
    char_item_t it;
    for (i = 0; i < lit.size(); i++) begin
      it.code = lit[i];
      it.last = (i == lit.size() - 1);
      it.mode = m;
      it.pause = pause && (i == 0);
      char_feed.push_back(it);
    end
    queued_chars += lit.size();
    lit.delete();
  endtask

  function automatic logic [7:0] digit_char(int v, bit upper);
    if (v < 10) return CHAR_ZERO + 8'(v);
    return (upper ? CHAR_UPPER_A : CHAR_LOWER_A) + 8'(v - 10);
  endfunction

  task automatic put_sign();
    case ($urandom_range(3))
      0: put_char(CHAR_MINUS);
      1: put_char(CHAR_PLUS);
      default: ;
    endcase
  endtask

  task automatic put_prefix(int kind);
    if (kind == LANE_DEC) begin
      put_sign();
    end else begin
      put_char(CHAR_ZERO);
      // an upper-case prefix letter must be rejected
      if ($urandom_range(19) == 0) put_char(LANE_PREFIX[kind] ^ 8'h20);
      else put_char(LANE_PREFIX[kind]);
    end
  endtask

  // values right at the digit limits and the 64-bit and signed bounds
  task automatic put_boundary(int kind);
    case (kind)
      LANE_BIN: begin
        put_text("0b");
        if ($urandom_range(1)) put_char(CHAR_ZERO);
        repeat (64) put_text("1");
      end
      LANE_OCT: begin
        case ($urandom_range(3))
          0: put_text("0o1777777777777777777777");
          1: put_text("0o2000000000000000000000");
          2: put_text("0o0000000000000000000000");
          default: put_text("0o00000000000000000000000");
        endcase
      end
      LANE_DEC: begin
        put_sign();
        case ($urandom_range(6))
          0: put_text("9223372036854775807");
          1: put_text("9223372036854775808");
          2: put_text("9223372036854775809");
          3: put_text("18446744073709551615");
          4: put_text("18446744073709551616");
          5: put_text("000000000000000000001");
          default: put_text("00000000000000000001");
        endcase
      end
      default: begin
        case ($urandom_range(3))
          0: put_text("0xFFFFFFFFFFFFFFFF");
          1: put_text("0x0FFFFFFFFFFFFFFFF");
          2: put_text("0xffffffffffffffff");
          default: put_text("0x10000000000000000");
        endcase
      end
    endcase
  endtask

  task automatic queue_random_literal();
    int         kind, r, ndig, i;
    logic [4:0] base;
    logic [2:0] m;
    kind = $urandom_range(3);
    base = LANE_BASE[kind];
    r = $urandom_range(99);
    if (r < 10) begin
      repeat ($urandom_range(1, 6)) put_char(8'($urandom_range(255)));
    end else if (r < 18) begin
      put_boundary(kind);
    end else if (r < 20) begin
      // long enough to saturate the position counter
      put_prefix(kind);
      put_text("1");
      repeat (130) put_char(CHAR_UNDERSCORE);
      put_char(CHAR_ZERO);
    end else begin
      put_prefix(kind);
      if ($urandom_range(3) == 0) ndig = $urandom_range(LANE_LIMIT[kind] + 2);
      else ndig = $urandom_range(1, 6);
      for (i = 0; i < ndig; i++) begin
        if ($urandom_range(9) == 0 && (i > 0 || $urandom_range(3) == 0))
          put_char(CHAR_UNDERSCORE);
        if ($urandom_range(39) == 0) put_char(8'($urandom_range(255)));
        else put_char(digit_char($urandom_range(base - 1), 1'($urandom_range(1))));
      end
    end
    r = $urandom_range(99);
    if (r < 60) m = MODE_BIN + 3'(kind);
    else if (r < 85) m = MODE_ANY;
    else m = 3'($urandom_range(7));
    send_literal(m, 1'b0);
  endtask

  // driver: offer the next queued character, hold it while stalled
  always @(negedge clk) begin : drive
    char_item_t cur;
    bit         offer;
    offer = 1'b0;
    if (in_valid && !in_taken) begin
      offer = 1'b1;
    end else if (!rst && char_feed.size() != 0 && (calm() || $urandom_range(99) >= 8)) begin
      if (!char_feed[0].pause || verdicts_due.size() == 0) begin
        cur = char_feed.pop_front();
        char_code <= cur.code;
        last_char <= cur.last;
        base_mode <= cur.mode;
        if (cur.pause) burst_go <= 1'b1;
        offer = 1'b1;
      end
    end
    in_valid <= offer;
  end

  // receiver stall, with one long hold while the single-character burst runs
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (burst_go && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm() && ($urandom_range(99) < 8);
    end
  end

  // monitor: predict on each taken character, check each taken verdict
  always @(posedge clk) begin : watch
    bit got, verdict, due;
    if (rst) begin
      in_taken <= 1'b0;
      quiet_cycles = 0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        chars_taken++;
        scan_char(char_code, last_char, base_mode, got, verdict);
        if (got) verdicts_due.push_back(verdict);
      end
      if (out_valid && !out_stall) begin
        verdicts_checked++;
        if (is_valid === 1'b1) valid_verdicts++;
        if (verdicts_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("verdict %0d: unexpected, is_valid=%b", verdicts_checked, is_valid);
        end else begin
          due = verdicts_due.pop_front();
          if (is_valid !== due) begin
            mismatches++;
            if (mismatches <= 10)
              $display("verdict %0d: is_valid expected %b, got %b",
                       verdicts_checked, due, is_valid);
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: nothing moved for %0d cycles", QUIET_LIMIT);
        $display("testbench failed");
        $finish;
      end
    end
  end

  initial begin
    clear_scan();

    put_text("0b1");  send_literal(MODE_BIN, 1'b0);
    put_text("0xFf"); send_literal(MODE_HEX, 1'b0);
    put_text("0o7");  send_literal(MODE_OCT, 1'b0);
    put_text("-9");   send_literal(MODE_DEC, 1'b0);
    // sign with no digits after it
    put_text("+");    send_literal(MODE_DEC, 1'b0);
    put_text("5");    send_literal(MODE_BAD, 1'b0);
    // NUL is just a bad character
    put_char(8'h00);  send_literal(MODE_ANY, 1'b0);
    put_char(8'hFF);  send_literal(MODE_ANY, 1'b0);
    put_text("_1");   send_literal(MODE_DEC, 1'b0);
    put_text("1_2");  send_literal(MODE_ANY, 1'b0);

    while (queued_chars < TARGET_CHARS) begin
      if (!burst_queued && queued_chars >= 700) begin
        // drain first, then a run of one-character literals to fill the block
        for (int i = 0; i < BURST_LEN; i++) begin
          put_char(CHAR_ZERO + 8'($urandom_range(9)));
          send_literal(3'($urandom_range(4)), i == 0);
        end
        burst_queued = 1'b1;
      end else begin
        queue_random_literal();
      end
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (char_feed.size() != 0 || in_valid || verdicts_due.size() != 0);
    repeat (20) @(negedge clk);

    $display("%0d characters taken, %0d literals judged (%0d valid), %0d mismatches",
             chars_taken, verdicts_checked, valid_verdicts, mismatches);
    $display("covered all modes, prefixes, signs, digit limits, 64-bit bounds and stalls");
    if (mismatches == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

endmodule

[sim.f]
hdl/ilv_pkg.sv
hdl/ilv_front.sv
hdl/ilv_queue.sv
hdl/ilv_back.sv
hdl/integer_literal_validator.sv
verif/testbench.sv
